>>> rtl/core/pcr_pkg.sv
// pcr_pkg: widths, register indexes, reset values and sequencer types
// for the particle cell rewrap block. No dependencies.
package pcr_pkg;

  localparam int POS_BITS  = 32;             // position word, 2^32 units per box
  localparam int CELL_BITS = 16;             // cell index
  localparam int CW_BITS   = POS_BITS + 1;   // cell width register
  localparam int HW_BITS   = POS_BITS;       // half cell width register
  localparam int WR_BITS   = CELL_BITS - 1;  // wait radius register
  localparam int CFG_BITS  = CW_BITS;        // widest register
  localparam int IDX_BITS  = 3;

  localparam int WP_BITS   = POS_BITS + 3;   // working position, signed
  localparam int CMP_BITS  = POS_BITS + 4;   // position compares, signed
  localparam int WC_BITS   = POS_BITS + 2;   // working cell index, signed
  localparam int DN_BITS   = POS_BITS;       // dividend
  localparam int DD_BITS   = POS_BITS + 1;   // divisor and remainder
  localparam int DCNT_BITS = $clog2(DN_BITS + 1);

  localparam logic [CELL_BITS-1:0] CELLS_RST  = 16'd64;
  localparam logic [CW_BITS-1:0]   CELL_W_RST = 33'd67108864;
  localparam logic [HW_BITS-1:0]   HALF_W_RST = 32'd33554432;
  localparam logic [CELL_BITS-1:0] Z_ORG_RST  = '0;
  localparam logic [WR_BITS-1:0]   WAIT_R_RST = 15'd2;

  typedef enum logic [IDX_BITS-1:0] {
    REG_CELLS  = 3'd0,
    REG_CELL_W = 3'd1,
    REG_HALF_W = 3'd2,
    REG_CLR_EN = 3'd3,
    REG_Z_ORG  = 3'd4,
    REG_WAIT_R = 3'd5
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UP   = 6'b000010,
    S_DN   = 6'b000100,
    S_DIV  = 6'b001000,
    S_WRAP = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    DM_UP   = 2'd0,
    DM_DN   = 2'd1,
    DM_WRAP = 2'd2
  } div_mode_t;

  // axis counter: x, y, z, then the z part of the sort key
  localparam logic [1:0] AX_Z   = 2'd2;
  localparam logic [1:0] AX_KEY = 2'd3;

endpackage

>>> rtl/core/particle_cell_rewrap.sv
// particle_cell_rewrap: rewraps a drifted particle into its new cell.
// Depends on pcr_pkg. One sequencer around a shared restoring divider.
//
//  channel | signals                               | dir | moves on
//  --------+---------------------------------------+-----+----------------------
//  in      | in_valid/in_ready, in_pos_*, old_cell_*| in  | valid & ready
//  out     | out_valid/out_ready, new_cell_*,      | out | valid & ready
//          | out_pos_*, sort_key, clear_light_cone,|     |
//          | too_far                               |     |
//  cfg     | cfg_we, cfg_index, cfg_data           | in  | cfg_we
//
// A word is accepted; then each axis takes an up step, a down step and an
// index wrap, the key is wrapped, and the output register is loaded. Any
// long step or wrap that misses the single-subtract fast path runs the
// shared divider instead of the one subtract.
// in_ready is high only while the sequencer is idle; the output register
// holds a finished word so the next one can be accepted meanwhile.
// rst is synchronous and restores the register reset values.
module particle_cell_rewrap
  import pcr_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [POS_BITS-1:0]  in_pos_x,
  input  logic signed [POS_BITS-1:0]  in_pos_y,
  input  logic signed [POS_BITS-1:0]  in_pos_z,
  input  logic [CELL_BITS-1:0]        old_cell_x,
  input  logic [CELL_BITS-1:0]        old_cell_y,
  input  logic [CELL_BITS-1:0]        old_cell_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [CELL_BITS-1:0]        new_cell_x,
  output logic [CELL_BITS-1:0]        new_cell_y,
  output logic [CELL_BITS-1:0]        new_cell_z,
  output logic signed [POS_BITS-1:0]  out_pos_x,
  output logic signed [POS_BITS-1:0]  out_pos_y,
  output logic signed [POS_BITS-1:0]  out_pos_z,
  output logic [2*CELL_BITS-1:0]      sort_key,
  output logic                        clear_light_cone,
  output logic                        too_far,
  input  logic                        cfg_we,
  input  logic [IDX_BITS-1:0]         cfg_index,
  input  logic [CFG_BITS-1:0]         cfg_data
);

  // configuration
  logic [CELL_BITS-1:0] cells_per_side;
  logic [CW_BITS-1:0]   cell_width;
  logic [HW_BITS-1:0]   half_cell_width;
  logic                 clear_enable;
  logic [CELL_BITS-1:0] z_origin;
  logic [WR_BITS-1:0]   wait_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_per_side  <= CELLS_RST;
      cell_width      <= CELL_W_RST;
      half_cell_width <= HALF_W_RST;
      clear_enable    <= 1'b0;
      z_origin        <= Z_ORG_RST;
      wait_radius     <= WAIT_R_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELLS:  cells_per_side  <= cfg_data[CELL_BITS-1:0];
        REG_CELL_W: cell_width      <= cfg_data[CW_BITS-1:0];
        REG_HALF_W: half_cell_width <= cfg_data[HW_BITS-1:0];
        REG_CLR_EN: clear_enable    <= cfg_data[0];
        REG_Z_ORG:  z_origin        <= cfg_data[CELL_BITS-1:0];
        REG_WAIT_R: wait_radius     <= cfg_data[WR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and working registers
  state_t                     state;
  div_mode_t                  mode;
  logic [1:0]                 ax;
  logic signed [WP_BITS-1:0]  p;
  logic signed [WC_BITS-1:0]  c;
  logic                       crossed;
  logic signed [POS_BITS-1:0] pend_pos [2];
  logic [CELL_BITS-1:0]       pend_cell [2];
  logic [CELL_BITS-1:0]       first_cell;
  logic [CELL_BITS-1:0]       ncell [3];
  logic [POS_BITS-1:0]        npos [3];
  logic [CELL_BITS-1:0]       key_lo;

  // shared divider
  logic [DN_BITS-1:0]   dq;
  logic [DD_BITS-1:0]   drem;
  logic [DD_BITS-1:0]   dd;
  logic [DCNT_BITS-1:0] dcnt;
  logic                 div_done;
  logic [DD_BITS:0]     dv_t;
  logic [DD_BITS:0]     dv_sub;
  logic                 dv_ge;

  assign div_done = dcnt == DCNT_BITS'(DN_BITS);
  assign dv_t     = {drem, dq[DN_BITS-1]};
  assign dv_sub   = dv_t - {1'b0, dd};
  assign dv_ge    = dv_t >= {1'b0, dd};

  // position step
  logic signed [CMP_BITS-1:0] p_ext, h_ext, w_ext, up_num, ph_sum, dn_num;
  logic                       w_nz, up_need, dn_need, up_fast, dn_fast;
  logic [DD_BITS-1:0]         k_sel, r_sel;
  logic signed [WC_BITS-1:0]  k_ext, n_ext, c_up, c_dn;
  logic [WP_BITS-1:0]         hz, rz, wz;
  logic signed [WP_BITS-1:0]  p_up, p_dn;
  logic                       x_up, x_dn;

  assign p_ext   = CMP_BITS'(p);
  assign h_ext   = $signed({{(CMP_BITS-HW_BITS){1'b0}}, half_cell_width});
  assign w_ext   = $signed({{(CMP_BITS-CW_BITS){1'b0}}, cell_width});
  assign up_num  = p_ext - h_ext;
  assign ph_sum  = p_ext + h_ext;
  assign dn_num  = ~ph_sum;           // -h - p - 1
  assign w_nz    = cell_width != '0;
  assign up_need = w_nz && !up_num[CMP_BITS-1];
  assign dn_need = w_nz && ph_sum[CMP_BITS-1];
  assign up_fast = up_num < w_ext;
  assign dn_fast = dn_num < w_ext;

  // steps are k = q + 1 with remainder r of (distance past the edge) / width
  always_comb begin
    if (state == S_DIV) begin
      k_sel = {1'b0, dq} + DD_BITS'(1);
      r_sel = drem;
    end else if (state == S_UP) begin
      k_sel = DD_BITS'(1);
      r_sel = up_num[DD_BITS-1:0];
    end else begin
      k_sel = DD_BITS'(1);
      r_sel = dn_num[DD_BITS-1:0];
    end
  end

  assign k_ext = $signed({{(WC_BITS-DD_BITS){1'b0}}, k_sel});
  assign n_ext = $signed({{(WC_BITS-CELL_BITS){1'b0}}, cells_per_side});
  assign c_up  = c + k_ext;
  assign c_dn  = c - k_ext;
  assign hz    = {{(WP_BITS-HW_BITS){1'b0}}, half_cell_width};
  assign wz    = {{(WP_BITS-CW_BITS){1'b0}}, cell_width};
  assign rz    = {{(WP_BITS-DD_BITS){1'b0}}, r_sel};
  assign p_up  = $signed(hz + rz - wz);
  assign p_dn  = $signed(wz - hz - rz - WP_BITS'(1));
  assign x_up  = (c < n_ext) && (c_up >= n_ext);
  assign x_dn  = c_dn[WC_BITS-1];

  // index wrap modulo cells_per_side
  logic signed [WC_BITS-1:0] c_sub, c_add, c_abs;
  logic                      c_neg, wrap_fast, wrap_done;
  logic [CELL_BITS-1:0]      fast_res, div_res, wrap_val, rem_lo;

  assign c_sub  = c - n_ext;
  assign c_add  = c + n_ext;
  assign c_neg  = c[WC_BITS-1];
  assign c_abs  = c_neg ? -c : c;
  assign rem_lo = drem[CELL_BITS-1:0];

  always_comb begin
    wrap_fast = 1'b1;
    fast_res  = '0;
    priority if (cells_per_side == '0) begin
      fast_res = '0;
    end else if (!c_neg && c < n_ext) begin
      fast_res = c[CELL_BITS-1:0];
    end else if (!c_neg && c_sub < n_ext) begin
      fast_res = c_sub[CELL_BITS-1:0];
    end else if (c_neg && !c_add[WC_BITS-1]) begin
      fast_res = c_add[CELL_BITS-1:0];
    end else begin
      wrap_fast = 1'b0;
    end
  end

  assign div_res   = !c_neg ? rem_lo : (rem_lo == '0 ? '0 : cells_per_side - rem_lo);
  assign wrap_done = (state == S_WRAP && wrap_fast) ||
                     (state == S_DIV && div_done && mode == DM_WRAP);
  assign wrap_val  = (state == S_DIV) ? div_res : fast_res;

  logic signed [CELL_BITS:0] key_diff;
  assign key_diff = $signed({1'b0, wrap_val}) - $signed({1'b0, z_origin});

  // periodic x distance against the wait radius
  logic signed [CELL_BITS:0]   dx;
  logic [CELL_BITS:0]          adx, half_n;
  logic signed [CELL_BITS+1:0] dfin;
  logic                        too_far_c;

  assign dx        = $signed({1'b0, first_cell}) - $signed({1'b0, ncell[0]});
  assign adx       = dx[CELL_BITS] ? (CELL_BITS+1)'(-dx) : dx;
  assign half_n    = ({1'b0, cells_per_side} + (CELL_BITS+1)'(1)) >> 1;
  assign dfin      = (adx >= half_n) ?
                     $signed({2'b00, cells_per_side}) - $signed({1'b0, adx}) :
                     $signed({1'b0, adx});
  assign too_far_c = dfin > $signed({{(CELL_BITS+2-WR_BITS){1'b0}}, wait_radius});

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mode      <= DM_UP;
      ax        <= '0;
      dcnt      <= '0;
      crossed   <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            p            <= WP_BITS'(in_pos_x);
            c            <= WC_BITS'(old_cell_x);
            pend_pos[0]  <= in_pos_y;
            pend_pos[1]  <= in_pos_z;
            pend_cell[0] <= old_cell_y;
            pend_cell[1] <= old_cell_z;
            first_cell   <= old_cell_x;
            ax           <= '0;
            crossed      <= 1'b0;
            state        <= S_UP;
          end
        end
        S_UP: begin
          if (up_need && up_fast) begin
            c       <= c_up;
            p       <= p_up;
            crossed <= crossed | x_up;
            state   <= S_DN;
          end else if (up_need) begin
            dq    <= up_num[DN_BITS-1:0];
            dd    <= cell_width;
            drem  <= '0;
            dcnt  <= '0;
            mode  <= DM_UP;
            state <= S_DIV;
          end else begin
            state <= S_DN;
          end
        end
        S_DN: begin
          if (dn_need && dn_fast) begin
            c       <= c_dn;
            p       <= p_dn;
            crossed <= crossed | x_dn;
            state   <= S_WRAP;
          end else if (dn_need) begin
            dq    <= dn_num[DN_BITS-1:0];
            dd    <= cell_width;
            drem  <= '0;
            dcnt  <= '0;
            mode  <= DM_DN;
            state <= S_DIV;
          end else begin
            state <= S_WRAP;
          end
        end
        S_DIV: begin
          if (!div_done) begin
            drem <= dv_ge ? dv_sub[DD_BITS-1:0] : dv_t[DD_BITS-1:0];
            dq   <= {dq[DN_BITS-2:0], dv_ge};
            dcnt <= dcnt + DCNT_BITS'(1);
          end else begin
            unique case (mode)
              DM_UP: begin
                c       <= c_up;
                p       <= p_up;
                crossed <= crossed | x_up;
                state   <= S_DN;
              end
              DM_DN: begin
                c       <= c_dn;
                p       <= p_dn;
                crossed <= crossed | x_dn;
                state   <= S_WRAP;
              end
              DM_WRAP: ;  // stored below
              default: state <= S_IDLE;
            endcase
          end
        end
        S_WRAP: begin
          if (!wrap_fast) begin
            dq    <= c_abs[DN_BITS-1:0];
            dd    <= {{(DD_BITS-CELL_BITS){1'b0}}, cells_per_side};
            drem  <= '0;
            dcnt  <= '0;
            mode  <= DM_WRAP;
            state <= S_DIV;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            new_cell_x       <= ncell[0];
            new_cell_y       <= ncell[1];
            new_cell_z       <= ncell[2];
            out_pos_x        <= npos[0];
            out_pos_y        <= npos[1];
            out_pos_z        <= npos[2];
            sort_key         <= {ncell[1], key_lo};
            clear_light_cone <= crossed & clear_enable;
            too_far          <= too_far_c;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // wrapped index ready: store it and move to the next axis or the key
      if (wrap_done) begin
        if (ax == AX_KEY) begin
          key_lo <= wrap_val;
          state  <= S_OUT;
        end else begin
          ncell[ax] <= wrap_val;
          npos[ax]  <= p[POS_BITS-1:0];
          if (ax == AX_Z) begin
            c     <= WC_BITS'(key_diff);
            ax    <= AX_KEY;
            state <= S_WRAP;
          end else begin
            p            <= WP_BITS'(pend_pos[0]);
            c            <= WC_BITS'(pend_cell[0]);
            pend_pos[0]  <= pend_pos[1];
            pend_cell[0] <= pend_cell[1];
            ax           <= ax + 2'd1;
            state        <= S_UP;
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/pcr_checker.sv
// pcr_checker: port-level assertions for particle_cell_rewrap, bound to it.
// Depends on pcr_pkg and the top level's port names.
module pcr_checker
  import pcr_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [CELL_BITS-1:0]       new_cell_x,
  input logic [CELL_BITS-1:0]       new_cell_y,
  input logic [CELL_BITS-1:0]       new_cell_z,
  input logic signed [POS_BITS-1:0] out_pos_x,
  input logic [2*CELL_BITS-1:0]     sort_key
);

  // in the cycle after an accept the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accept");

  // a new result shows up only as the sequencer returns to idle
  a_result_at_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready && !$past(in_ready))
    else $error("result appeared without a finished word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_cell_x) &&
      $stable(out_pos_x) && $stable(sort_key))
    else $error("stalled output word changed");

  // high half of the key is the new y cell
  a_key_y: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sort_key[2*CELL_BITS-1:CELL_BITS] == new_cell_y)
    else $error("sort key high half differs from new_cell_y");

  // wrapped indices stay below the largest cell count
  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> new_cell_x != '1 && new_cell_y != '1 && new_cell_z != '1)
    else $error("new cell index out of range");

endmodule

bind particle_cell_rewrap pcr_checker u_pcr_checker (.*);
